[rtl/swrms_pkg.sv]
package swrms_pkg;

    // sample and gain formats
    localparam int SAMPLE_BITS     = 24;
    localparam int RAMP_COUNT_BITS = 16;
    localparam int WP_BITS         = 8;
    localparam int GAIN_BITS       = 32;   // unsigned Q2.30, holds 0 .. 2.0
    localparam int GAIN_FRAC       = 30;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(64'd1 << GAIN_FRAC);
    localparam logic [GAIN_BITS-1:0] GAIN_MAX = GAIN_BITS'(64'd1 << (GAIN_FRAC + 1));
    localparam logic [GAIN_BITS-1:0] INC_POS_MAX = {1'b0, {(GAIN_BITS-1){1'b1}}};

    // width target: round(wp * 2^30 / 100), wp clamped to 200
    localparam logic [WP_BITS-1:0] WP_MAX   = WP_BITS'(200);
    localparam logic [WP_BITS-1:0] WP_RESET = WP_BITS'(100);
    localparam logic [RAMP_COUNT_BITS-1:0] RAMP_RESET = RAMP_COUNT_BITS'(240);
    localparam int PCT_DIV    = 100;
    localparam int ROUND_HALF = PCT_DIV / 2;

    // target = wp * (2^30 div 100) + (wp * (2^30 mod 100) + 50) div 100
    localparam logic [GAIN_BITS-1:0] TGT_UNIT =
        GAIN_BITS'((64'd1 << GAIN_FRAC) / PCT_DIV);
    localparam int TGT_REM = int'((64'd1 << GAIN_FRAC) % PCT_DIV);
    // residue is at most 200 * 24 + 50 = 4850; x * 5243 >> 19 is x div 100 there
    localparam int RES_BITS  = 13;
    localparam int RCP_MUL   = 5243;
    localparam int RCP_SHIFT = 19;
    localparam int RCP_BITS  = RES_BITS + 13;

    // divider sizing (ramp increment, |delta| <= 2^31)
    localparam int DIV_NUM_BITS = GAIN_BITS;
    localparam int DIV_DEN_BITS = RAMP_COUNT_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS);

    // mid/side datapath sizing
    localparam int SUM_BITS  = SAMPLE_BITS + 1;
    localparam int PROD_BITS = SUM_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 1;
    localparam int SH_BITS   = ACC_BITS - GAIN_FRAC - 1;
    localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(64'd1 << GAIN_FRAC);
    localparam logic signed [SH_BITS-1:0]  SAT_HI   =
        SH_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [SH_BITS-1:0]  SAT_LO   = ~SAT_HI;

    // configuration register map
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP  = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_word;

    typedef struct packed {
        logic                    start;
        logic [DIV_NUM_BITS-1:0] num;
        logic [DIV_DEN_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic [DIV_NUM_BITS-1:0] quo;
    } t_div_rsp;

endpackage

[rtl/swrms_div.sv]
module swrms_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swrms_pkg::t_div_req i_req,
    output swrms_pkg::t_div_rsp o_rsp
);

    localparam int NB = swrms_pkg::DIV_NUM_BITS;
    localparam int DB = swrms_pkg::DIV_DEN_BITS;
    localparam int CB = swrms_pkg::DIV_CNT_BITS;

    logic          r_busy;
    logic          r_done;
    logic [CB-1:0] r_cnt;
    logic [NB-1:0] r_quo;
    logic [DB-1:0] r_rem;
    logic [DB-1:0] r_den;

    logic [DB:0]   w_shift;
    logic          w_ge;

    // one restoring step: shift in the next dividend bit, trial subtract
    assign w_shift = {r_rem, r_quo[NB-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CB'(1);
                if (r_cnt == CB'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DB'(w_shift - {1'b0, r_den}) : w_shift[DB-1:0];
            r_quo <= {r_quo[NB-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[rtl/stereo_width_ramped_mid_side_top.sv]
// channel   | handshake                 | word
// ----------+---------------------------+--------------------------------
// input     | i_in_valid / o_in_ready   | i_in_data  (left_in, right_in)
// output    | o_out_valid / i_out_ready | o_out_data (left_out, right_out)
// config    | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// The result word is registered after a frame is taken through the steps decide, gain
// step, multiply and round; a new ramp first runs the 32-step restoring divider for the
// increment between decide and gain step. Ready returns with the word. Synchronous
// active-low reset; the gain jumps to the target on the first frame after reset. A
// stalled output word holds in its register; the next frame is taken meanwhile and
// waits in the last step until it frees.
module stereo_width_ramped_mid_side_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  swrms_pkg::t_in_word                    i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output swrms_pkg::t_out_word                   o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [swrms_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [swrms_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int SB = swrms_pkg::SAMPLE_BITS;
    localparam int GB = swrms_pkg::GAIN_BITS;
    localparam int RB = swrms_pkg::RAMP_COUNT_BITS;
    localparam int WB = swrms_pkg::WP_BITS;
    localparam int AB = swrms_pkg::ACC_BITS;
    localparam int HB = swrms_pkg::SH_BITS;
    localparam int XB = swrms_pkg::RES_BITS;
    localparam int MB = swrms_pkg::RCP_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TGT   = 3'd1;
    localparam logic [2:0] ST_INC   = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]                                r_state;
    logic [WB-1:0]                             r_wp;
    logic [RB-1:0]                             r_ramp;
    logic [GB-1:0]                             r_gain_now;
    logic [GB-1:0]                             r_gain_goal;
    logic [GB-1:0]                             r_gain_inc;
    logic [RB-1:0]                             r_frames;
    logic                                      r_primed;
    logic [GB-1:0]                             r_target;
    logic                                      r_inc_neg;
    logic signed [SB-1:0]                      r_left;
    logic signed [SB-1:0]                      r_right;
    logic signed [swrms_pkg::PROD_BITS-1:0]    r_prod;
    logic                                      r_out_valid;
    swrms_pkg::t_out_word                      r_out_data;

    swrms_pkg::t_div_req w_div_req;
    swrms_pkg::t_div_rsp w_div_rsp;

    logic                                      w_accept;
    logic                                      w_out_free;
    logic [WB-1:0]                             w_wp_clamp;
    logic [XB-1:0]                             w_tgt_res;
    logic [MB-1:0]                             w_tgt_rcp;
    logic [RB-1:0]                             w_ramp_eff;
    logic [GB-1:0]                             w_target;
    logic signed [GB:0]                        w_delta;
    logic [GB:0]                               w_delta_mag;
    logic                                      w_new_ramp;
    logic [GB-1:0]                             w_quo;
    logic [GB-1:0]                             n_gain_inc;
    logic signed [GB+1:0]                      w_gain_sum;
    logic [GB-1:0]                             n_gain_now;
    logic signed [swrms_pkg::SUM_BITS-1:0]     w_sum;
    logic signed [swrms_pkg::SUM_BITS-1:0]     w_diff;
    logic signed [GB:0]                        w_gain_s;
    logic signed [swrms_pkg::PROD_BITS-1:0]    w_prod;
    logic signed [AB-1:0]                      w_base;
    logic signed [AB-1:0]                      w_acc_l;
    logic signed [AB-1:0]                      w_acc_r;

    function automatic logic signed [SB-1:0] sat_sample(input logic signed [HB-1:0] v);
        logic signed [HB-1:0] c;
        begin
            c = v;
            if (v > swrms_pkg::SAT_HI) begin
                c = swrms_pkg::SAT_HI;
            end else if (v < swrms_pkg::SAT_LO) begin
                c = swrms_pkg::SAT_LO;
            end
            sat_sample = c[SB-1:0];
        end
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // width target by constant multiplies, residue divided by reciprocal
    assign w_wp_clamp  = (r_wp > swrms_pkg::WP_MAX) ? swrms_pkg::WP_MAX : r_wp;
    assign w_tgt_res   = XB'(w_wp_clamp) * XB'(swrms_pkg::TGT_REM)
                         + XB'(swrms_pkg::ROUND_HALF);
    assign w_tgt_rcp   = MB'(w_tgt_res) * MB'(swrms_pkg::RCP_MUL);
    assign w_target    = GB'(w_wp_clamp) * swrms_pkg::TGT_UNIT
                         + GB'(w_tgt_rcp[MB-1:swrms_pkg::RCP_SHIFT]);

    // ramp setup terms
    assign w_ramp_eff  = (r_ramp == '0) ? RB'(1) : r_ramp;
    assign w_delta     = $signed({1'b0, r_target}) - $signed({1'b0, r_gain_now});
    assign w_delta_mag = w_delta[GB] ? (GB+1)'(-w_delta) : w_delta;
    assign w_new_ramp  = r_primed && (r_target != r_gain_goal);

    // divider request: increment magnitude on a new ramp
    assign w_div_req.start = (r_state == ST_TGT) && w_new_ramp;
    assign w_div_req.num   = w_delta_mag[GB-1:0];
    assign w_div_req.den   = w_ramp_eff;

    swrms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // increment: sign back on, saturate to signed 32
    assign w_quo = w_div_rsp.quo[GB-1:0];
    always_comb begin
        if (r_inc_neg) begin
            n_gain_inc = -w_quo;
        end else if (w_quo[GB-1]) begin
            n_gain_inc = swrms_pkg::INC_POS_MAX;
        end else begin
            n_gain_inc = w_quo;
        end
    end

    // ramp step with clamp to [0, 2.0], forced onto goal on the last frame
    assign w_gain_sum = $signed({2'b00, r_gain_now})
                        + $signed({{2{r_gain_inc[GB-1]}}, r_gain_inc});
    always_comb begin
        if (r_frames == RB'(1)) begin
            n_gain_now = r_gain_goal;
        end else if (w_gain_sum < 0) begin
            n_gain_now = '0;
        end else if (w_gain_sum > $signed({2'b00, swrms_pkg::GAIN_MAX})) begin
            n_gain_now = swrms_pkg::GAIN_MAX;
        end else begin
            n_gain_now = w_gain_sum[GB-1:0];
        end
    end

    // mid/side mix
    assign w_sum    = $signed({r_left[SB-1], r_left}) + $signed({r_right[SB-1], r_right});
    assign w_diff   = $signed({r_left[SB-1], r_left}) - $signed({r_right[SB-1], r_right});
    assign w_gain_s = $signed({1'b0, r_gain_now});
    assign w_prod   = w_diff * w_gain_s;
    assign w_base   = ($signed({{(AB-swrms_pkg::SUM_BITS){w_sum[swrms_pkg::SUM_BITS-1]}}, w_sum})
                      <<< swrms_pkg::GAIN_FRAC) + swrms_pkg::ACC_HALF;
    assign w_acc_l  = w_base + $signed({r_prod[swrms_pkg::PROD_BITS-1], r_prod});
    assign w_acc_r  = w_base - $signed({r_prod[swrms_pkg::PROD_BITS-1], r_prod});

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= swrms_pkg::WP_RESET;
            r_ramp <= swrms_pkg::RAMP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swrms_pkg::CFG_WIDTH: r_wp   <= i_cfg_data[WB-1:0];
                swrms_pkg::CFG_RAMP:  r_ramp <= i_cfg_data[RB-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and gain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain_now  <= swrms_pkg::GAIN_ONE;
            r_gain_goal <= swrms_pkg::GAIN_ONE;
            r_gain_inc  <= '0;
            r_frames    <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the last step reloads the output word itself
            if (r_out_valid && i_out_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_TGT;
                    end
                end
                ST_TGT: begin
                    if (!r_primed) begin
                        r_gain_now  <= r_target;
                        r_gain_goal <= r_target;
                        r_primed    <= 1'b1;
                        r_state     <= ST_APPLY;
                    end else if (w_new_ramp) begin
                        r_state <= ST_INC;
                    end else begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_INC: begin
                    if (w_div_rsp.done) begin
                        r_gain_inc  <= n_gain_inc;
                        r_gain_goal <= r_target;
                        r_frames    <= w_ramp_eff;
                        r_state     <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (r_frames != '0) begin
                        r_gain_now <= n_gain_now;
                        r_frames   <= r_frames - RB'(1);
                    end
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left   <= i_in_data.left_in;
            r_right  <= i_in_data.right_in;
            r_target <= w_target;
        end
        if (r_state == ST_TGT) begin
            r_inc_neg <= w_delta[GB];
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_prod;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out_data.left_out  <= sat_sample(w_acc_l[AB-1:swrms_pkg::GAIN_FRAC+1]);
            r_out_data.right_out <= sat_sample(w_acc_r[AB-1:swrms_pkg::GAIN_FRAC+1]);
        end
    end

endmodule

[rtl/swrms_chk.sv]
module swrms_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input swrms_pkg::t_out_word o_out_data
);

    // block comes out of reset ready for a word
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

    // one frame at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    // a result only appears at the end of a frame's work
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while idle");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind stereo_width_ramped_mid_side_top swrms_chk u_swrms_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
